// ===== design/als3d_pkg.sv =====
// ----------------------------------------------------------------------------
// Stencil package
// Types and constants shared by the anisotropic Laplacian stencil block.
// ----------------------------------------------------------------------------
`default_nettype none

package als3d_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SAMPLE_W   = 24;
    localparam int RATE_W     = 44;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LONG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TRANS = 3'd4;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_MUL,
        ST_SUM
    } state_t;

    // Order in which the stencil taps are read from the grid memory.
    typedef enum logic [2:0] {
        SL_C,
        SL_L,
        SL_R,
        SL_U,
        SL_D,
        SL_I,
        SL_O
    } slot_t;

endpackage

`default_nettype wire

// ===== design/als3d_ram.sv =====
// ----------------------------------------------------------------------------
// Single-port RAM
// Generic synchronous RAM with one port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module als3d_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                       wdata,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

`default_nettype wire

// ===== design/anisotropic_laplacian_stencil_3d_top.sv =====
// A write transfer is stored in the cycle it is taken; writes run one per cycle while
// no compute is in progress. A compute transfer holds off new items through its read,
// drain, multiply and sum states: the seven grid reads share the single RAM port.
// A finished result waits in the output register while the next item is taken.
// Reset clears the control state and loads the size and coefficient registers;
// grid contents are undefined until written and get no clearing pass.
// ----------------------------------------------------------------------------
// Anisotropic seven-point Laplacian stencil, top level
// Stores a 3D concentration grid and returns the diffusion rate at a voxel.
// ----------------------------------------------------------------------------
`default_nettype none

module anisotropic_laplacian_stencil_3d_top #(
    parameter int MAX_X = 16,
    parameter int MAX_Y = 16,
    parameter int MAX_Z = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,    // pos_x, pos_y, pos_z, sample
    input  wire logic        s_tuser,    // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata,    // out_x, out_y, out_z, flux_rate
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [als3d_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [als3d_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH  = MAX_X * MAX_Y * MAX_Z;
    localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam logic [ADDR_W-1:0] STEP_Y = ADDR_W'(MAX_X);
    localparam logic [ADDR_W-1:0] STEP_Z = ADDR_W'(MAX_X * MAX_Y);

    als3d_pkg::state_t state_reg, state_next;
    als3d_pkg::slot_t  rd_idx_reg, rd_idx_next;
    als3d_pkg::slot_t  slot_reg;

    logic [4:0]  dim_x_reg, dim_y_reg;
    logic [6:0]  dim_z_reg;
    logic [31:0] coef_long_reg, coef_trans_reg;

    logic [3:0]  x_reg, y_reg;
    logic [5:0]  z_reg;
    logic [ADDR_W-1:0] centre_reg;
    logic        live_reg, live_next;
    logic [23:0] c_reg;
    logic [25:0] sum_l_reg, sum_t_reg;
    logic signed [59:0] prod_l_reg;
    logic signed [60:0] prod_t_reg;
    logic        m_valid_reg;
    logic [63:0] m_data_reg;

    logic [3:0]  pos_x, pos_y;
    logic [5:0]  pos_z;
    logic [23:0] sample;
    logic [4:0]  nx, ny;
    logic [6:0]  nz;
    logic        in_range;
    logic        accept;
    logic [31:0] in_addr_full;
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] nb_addr;
    logic        ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [23:0] ram_rdata;
    logic        out_free;
    logic        load_out;
    logic signed [26:0] dl;
    logic signed [27:0] dt;
    logic signed [61:0] total;

    assign pos_x  = s_tdata[3:0];
    assign pos_y  = s_tdata[7:4];
    assign pos_z  = s_tdata[13:8];
    assign sample = s_tdata[37:14];

    assign nx = (32'(dim_x_reg) > MAX_X) ? 5'(MAX_X) : dim_x_reg;
    assign ny = (32'(dim_y_reg) > MAX_Y) ? 5'(MAX_Y) : dim_y_reg;
    assign nz = (32'(dim_z_reg) > MAX_Z) ? 7'(MAX_Z) : dim_z_reg;

    assign in_range = ({1'b0, pos_x} < nx) && ({1'b0, pos_y} < ny) && ({1'b0, pos_z} < nz);
    assign accept   = s_tvalid && s_tready;

    assign in_addr_full = 32'(pos_x) + 32'(pos_y) * 32'(MAX_X)
                        + 32'(pos_z) * 32'(MAX_X * MAX_Y);
    assign in_addr      = ADDR_W'(in_addr_full);

    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // A neighbour beyond the grid edge reads the centre voxel instead.
    always_comb
    begin
        nb_addr = centre_reg;
        case (rd_idx_reg)
            als3d_pkg::SL_L: if (x_reg != 4'd0) nb_addr = centre_reg - ADDR_W'(1);
            als3d_pkg::SL_R: if (5'(x_reg) + 5'd1 != nx) nb_addr = centre_reg + ADDR_W'(1);
            als3d_pkg::SL_U: if (y_reg != 4'd0) nb_addr = centre_reg - STEP_Y;
            als3d_pkg::SL_D: if (5'(y_reg) + 5'd1 != ny) nb_addr = centre_reg + STEP_Y;
            als3d_pkg::SL_I: if (z_reg != 6'd0) nb_addr = centre_reg - STEP_Z;
            als3d_pkg::SL_O: if (7'(z_reg) + 7'd1 != nz) nb_addr = centre_reg + STEP_Z;
            default:         nb_addr = centre_reg;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        case (state_reg)
            als3d_pkg::ST_IDLE:
            begin
                if (accept && in_range && s_tuser == als3d_pkg::CMD_COMPUTE)
                begin
                    state_next  = als3d_pkg::ST_READ;
                    rd_idx_next = als3d_pkg::SL_L;
                end
            end
            als3d_pkg::ST_READ:
            begin
                if (rd_idx_reg == als3d_pkg::SL_O)
                begin
                    state_next = als3d_pkg::ST_DRAIN;
                end
                else
                begin
                    rd_idx_next = als3d_pkg::slot_t'(rd_idx_reg + 3'd1);
                end
            end
            als3d_pkg::ST_DRAIN: state_next = als3d_pkg::ST_MUL;
            als3d_pkg::ST_MUL:   state_next = als3d_pkg::ST_SUM;
            als3d_pkg::ST_SUM:
            begin
                if (out_free)
                begin
                    state_next = als3d_pkg::ST_IDLE;
                end
            end
            default: state_next = als3d_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = nb_addr;
        live_next = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            als3d_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                ram_addr  = in_addr;
                ram_we    = accept && in_range && s_tuser == als3d_pkg::CMD_WRITE;
                live_next = accept && in_range && s_tuser == als3d_pkg::CMD_COMPUTE;
            end
            als3d_pkg::ST_READ: live_next = 1'b1;
            als3d_pkg::ST_SUM:  load_out  = out_free;
            default:
            begin
                live_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= als3d_pkg::ST_IDLE;
            rd_idx_reg     <= als3d_pkg::SL_C;
            live_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            dim_x_reg      <= 5'd16;
            dim_y_reg      <= 5'd16;
            dim_z_reg      <= 7'd64;
            coef_long_reg  <= 32'd0;
            coef_trans_reg <= 32'd0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            live_reg   <= live_next;
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    als3d_pkg::REG_DIM_X:      dim_x_reg      <= cfg_data[4:0];
                    als3d_pkg::REG_DIM_Y:      dim_y_reg      <= cfg_data[4:0];
                    als3d_pkg::REG_DIM_Z:      dim_z_reg      <= cfg_data[6:0];
                    als3d_pkg::REG_COEF_LONG:  coef_long_reg  <= cfg_data;
                    als3d_pkg::REG_COEF_TRANS: coef_trans_reg <= cfg_data;
                    default:                   dim_x_reg      <= dim_x_reg;
                endcase
            end
        end
    end

    assign dl    = $signed({1'b0, sum_l_reg}) - $signed({2'b00, c_reg, 1'b0});
    assign dt    = $signed({2'b00, sum_t_reg}) - $signed({2'b00, c_reg, 2'b00});
    assign total = 62'(prod_l_reg) + 62'(prod_t_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == als3d_pkg::ST_IDLE && live_next)
        begin
            x_reg      <= pos_x;
            y_reg      <= pos_y;
            z_reg      <= pos_z;
            centre_reg <= in_addr;
            sum_l_reg  <= 26'd0;
            sum_t_reg  <= 26'd0;
        end
        slot_reg <= (state_reg == als3d_pkg::ST_READ) ? rd_idx_reg : als3d_pkg::SL_C;
        if (live_reg)
        begin
            case (slot_reg)
                als3d_pkg::SL_C: c_reg <= ram_rdata;
                als3d_pkg::SL_L,
                als3d_pkg::SL_R: sum_l_reg <= sum_l_reg + 26'(ram_rdata);
                als3d_pkg::SL_U,
                als3d_pkg::SL_D,
                als3d_pkg::SL_I,
                als3d_pkg::SL_O: sum_t_reg <= sum_t_reg + 26'(ram_rdata);
                default:         c_reg <= c_reg;
            endcase
        end
        if (state_reg == als3d_pkg::ST_MUL)
        begin
            prod_l_reg <= dl * $signed({1'b0, coef_long_reg});
            prod_t_reg <= dt * $signed({1'b0, coef_trans_reg});
        end
        if (load_out)
        begin
            m_data_reg <= {6'd0, total[59:16], z_reg, y_reg, x_reg};
        end
    end

    als3d_ram #(
        .WIDTH (als3d_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (sample),
        .rdata (ram_rdata)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == als3d_pkg::ST_IDLE)
        else $error("grid written outside the idle state");

    assert property (@(posedge clk) disable iff (!rst_n)
        live_reg |-> (state_reg == als3d_pkg::ST_READ || state_reg == als3d_pkg::ST_DRAIN))
        else $error("read data arriving outside the read phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == als3d_pkg::ST_SUM))
        else $error("result raised without a finished computation");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == als3d_pkg::ST_READ |-> rd_idx_reg != als3d_pkg::SL_C)
        else $error("centre voxel read again in the neighbour phase");

endmodule

`default_nettype wire
